>>> rtl/bgr_pkg.sv
// Shared types and constants for the bitmap glyph rasterizer.
package bgr_pkg;

   localparam int ROW_W     = 3;   // row index bits, eight rows per glyph
   localparam int CELL_COLS = 8;   // columns in a character cell
   localparam int SCALE_MAX = 64;

   // item function codes
   localparam logic [1:0] FUNC_LOAD      = 2'd0;
   localparam logic [1:0] FUNC_DRAW      = 2'd1;
   localparam logic [1:0] FUNC_DRAW_CLIP = 2'd2;

   // configuration register indexes
   localparam logic CSR_GLYPH_WIDTH = 1'b0;
   localparam logic CSR_ROW_SHIFT   = 1'b1;

   localparam logic [3:0] GLYPH_WIDTH_RESET = 4'd8;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } bgr_state_type;

   // horizontal clip request for one glyph dot
   typedef struct packed {
      logic               clipped;
      logic signed [17:0] px;
      logic [6:0]         scale;
      logic signed [15:0] min_x;
      logic signed [15:0] max_x;
      logic               y_ok;
   } bgr_xreq_type;

   // clamped horizontal span of one dot
   typedef struct packed {
      logic               ok;
      logic signed [16:0] x;
      logic [6:0]         w;
   } bgr_xspan_type;

endpackage

>>> rtl/bgr_glyph_mem.sv
// Glyph row store: one write port, one registered read port, zeroing sweep after reset.
module bgr_glyph_mem import bgr_pkg::*; #(
   parameter int GLYPH_COUNT = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [$clog2(GLYPH_COUNT)+ROW_W-1:0] wr_addr,
   input  logic [7:0]                           wr_data,
   input  logic                                 rd_en,
   input  logic [$clog2(GLYPH_COUNT)+ROW_W-1:0] rd_addr,
   output logic [7:0]                           rd_data,
   output logic                                 busy
);

   localparam int ADDR_W = $clog2(GLYPH_COUNT) + ROW_W;
   localparam int DEPTH  = GLYPH_COUNT * CELL_COLS;

   logic [7:0]        mem [DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              busy_ff, busy_in;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;

   always_comb begin
      sweep_in = sweep_ff;
      busy_in  = busy_ff;
      if (busy_ff) begin
         if (sweep_ff == ADDR_W'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end else begin
            sweep_in = sweep_ff + 1'b1;
         end
      end
   end

   // the sweep owns the write port until every entry is blank
   assign mem_we    = busy_ff | wr_en;
   assign mem_waddr = busy_ff ? sweep_ff : wr_addr;
   assign mem_wdata = busy_ff ? 8'd0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         sweep_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

>>> rtl/bgr_rect_clip.sv
// Horizontal clamp of one glyph dot against the clip rectangle.
module bgr_rect_clip import bgr_pkg::*; (
   input  bgr_xreq_type  xreq,
   output bgr_xspan_type xspan
);

   logic signed [17:0] scale_s;
   logic signed [17:0] px_end;
   logic signed [17:0] min_x;
   logic signed [17:0] max_x;
   logic signed [17:0] x1;
   logic signed [17:0] x2;
   logic signed [17:0] span;

   always_comb begin
      scale_s = $signed({11'd0, xreq.scale});
      px_end  = xreq.px + scale_s;
      min_x   = 18'(xreq.min_x);
      max_x   = 18'(xreq.max_x);
      x1      = (xreq.px > min_x) ? xreq.px : min_x;
      x2      = (px_end < max_x) ? px_end : max_x;
      span    = x2 - x1;
      if (xreq.clipped) begin
         xspan.ok = (x2 > x1) && xreq.y_ok;
         xspan.x  = 17'(x1);
         xspan.w  = 7'(span);
      end else begin
         xspan.ok = 1'b1;
         xspan.x  = 17'(xreq.px);
         xspan.w  = xreq.scale;
      end
   end

endmodule

>>> rtl/bgr_draw_seq.sv
// Item sequencer: loads, row reads, column scan, result hold and output register.
module bgr_draw_seq import bgr_pkg::*; #(
   parameter int GLYPH_COUNT = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_func,
   input  logic [7:0]                           req_char_code,
   input  logic [2:0]                           req_row_index,
   input  logic [7:0]                           req_row_bits,
   input  logic signed [15:0]                   req_origin_x,
   input  logic signed [15:0]                   req_origin_y,
   input  logic [6:0]                           req_scale,
   input  logic [31:0]                          req_colour,
   input  logic signed [15:0]                   req_clip_min_x,
   input  logic signed [15:0]                   req_clip_min_y,
   input  logic signed [15:0]                   req_clip_max_x,
   input  logic signed [15:0]                   req_clip_max_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [16:0]                   rsp_rect_x,
   output logic signed [16:0]                   rsp_rect_y,
   output logic [6:0]                           rsp_rect_w,
   output logic [6:0]                           rsp_rect_h,
   output logic [31:0]                          rsp_rect_colour,
   output logic                                 rsp_empty_res,
   output logic                                 rsp_last,
   input  logic [3:0]                           glyph_width,
   input  logic [2:0]                           row_shift,
   input  logic                                 mem_busy,
   output logic                                 mem_wr_en,
   output logic [$clog2(GLYPH_COUNT)+ROW_W-1:0] mem_wr_addr,
   output logic [7:0]                           mem_wr_data,
   output logic                                 mem_rd_en,
   output logic [$clog2(GLYPH_COUNT)+ROW_W-1:0] mem_rd_addr,
   input  logic [7:0]                           mem_rd_data
);

   localparam int CODE_W = $clog2(GLYPH_COUNT);

   bgr_state_type      state_ff, state_in;
   logic               clipped_ff, clipped_in;
   logic               blank_ff, blank_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic [2:0]         row_ff, row_in;
   logic [2:0]         col_ff, col_in;
   logic [2:0]         col_lo_ff, col_lo_in;
   logic [3:0]         col_hi_ff, col_hi_in;
   logic [6:0]         scale_ff, scale_in;
   logic signed [15:0] ox_ff, ox_in;
   logic signed [17:0] px_ff, px_in;
   logic signed [17:0] py_ff, py_in;
   logic [31:0]        colour_ff, colour_in;
   logic signed [15:0] min_x_ff, min_x_in;
   logic signed [15:0] min_y_ff, min_y_in;
   logic signed [15:0] max_x_ff, max_x_in;
   logic signed [15:0] max_y_ff, max_y_in;
   logic signed [16:0] y_ff, y_in;
   logic [6:0]         h_ff, h_in;
   logic               y_ok_ff, y_ok_in;
   logic               hold_v_ff, hold_v_in;
   logic signed [16:0] hold_x_ff, hold_x_in;
   logic signed [16:0] hold_y_ff, hold_y_in;
   logic [6:0]         hold_w_ff, hold_w_in;
   logic [6:0]         hold_h_ff, hold_h_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [16:0] rsp_x_ff, rsp_x_in;
   logic signed [16:0] rsp_y_ff, rsp_y_in;
   logic [6:0]         rsp_w_ff, rsp_w_in;
   logic [6:0]         rsp_h_ff, rsp_h_in;
   logic [31:0]        rsp_colour_ff, rsp_colour_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               accept;
   logic               code_ok;
   logic [3:0]         width_eff;
   logic [2:0]         col_off;
   logic [6:0]         scale_eff;
   logic signed [17:0] scale_s;
   logic signed [17:0] py_end;
   logic signed [17:0] y_lo;
   logic signed [17:0] y_hi;
   logic [7:0]         row_data;
   logic               dot;
   logic               in_col;
   logic               emit;
   logic               out_free;
   logic               stall;
   bgr_xreq_type       xreq;
   bgr_xspan_type      xspan;

   assign req_ready = (state_ff == ST_IDLE) && !mem_busy;
   assign accept    = req_valid && req_ready;
   assign code_ok   = 9'(req_char_code) < 9'(GLYPH_COUNT);

   // widths outside 1..8 use the full cell; the used columns sit centered
   assign width_eff = (glyph_width >= 4'd1 && glyph_width <= 4'(CELL_COLS)) ?
                      glyph_width : 4'(CELL_COLS);
   assign col_off   = 3'((4'(CELL_COLS) - width_eff) >> 1);
   assign scale_eff = (req_scale == 7'd0) ? 7'd1 :
                      (req_scale > 7'(SCALE_MAX)) ? 7'(SCALE_MAX) : req_scale;

   assign scale_s = $signed({11'd0, scale_ff});
   assign py_end  = py_ff + scale_s;
   assign y_lo    = (py_ff > 18'(min_y_ff)) ? py_ff : 18'(min_y_ff);
   assign y_hi    = (py_end < 18'(max_y_ff)) ? py_end : 18'(max_y_ff);

   assign row_data = blank_ff ? 8'd0 : (mem_rd_data << row_shift);
   assign dot      = row_data[3'd7 - col_ff];
   assign in_col   = (col_ff >= col_lo_ff) && ({1'b0, col_ff} < col_hi_ff);

   always_comb begin
      xreq.clipped = clipped_ff;
      xreq.px      = px_ff;
      xreq.scale   = scale_ff;
      xreq.min_x   = min_x_ff;
      xreq.max_x   = max_x_ff;
      xreq.y_ok    = y_ok_ff;
   end

   bgr_rect_clip u_clip (
      .xreq  (xreq),
      .xspan (xspan)
   );

   assign emit     = (state_ff == ST_SCAN) && dot && in_col && xspan.ok;
   assign out_free = !rsp_valid_ff || rsp_ready;
   // a new square can only park in the hold stage once the old one has moved on
   assign stall    = emit && hold_v_ff && !out_free;

   assign mem_wr_addr = {req_char_code[CODE_W-1:0], req_row_index};
   assign mem_wr_data = req_row_bits;
   assign mem_rd_addr = {code_ff, row_ff};

   always_comb begin
      state_in      = state_ff;
      clipped_in    = clipped_ff;
      blank_in      = blank_ff;
      code_in       = code_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      col_lo_in     = col_lo_ff;
      col_hi_in     = col_hi_ff;
      scale_in      = scale_ff;
      ox_in         = ox_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      colour_in     = colour_ff;
      min_x_in      = min_x_ff;
      min_y_in      = min_y_ff;
      max_x_in      = max_x_ff;
      max_y_in      = max_y_ff;
      y_in          = y_ff;
      h_in          = h_ff;
      y_ok_in       = y_ok_ff;
      hold_v_in     = hold_v_ff;
      hold_x_in     = hold_x_ff;
      hold_y_in     = hold_y_ff;
      hold_w_in     = hold_w_ff;
      hold_h_in     = hold_h_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_w_in      = rsp_w_ff;
      rsp_h_in      = rsp_h_ff;
      rsp_colour_in = rsp_colour_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FUNC_LOAD: begin
                     mem_wr_en = code_ok;
                  end
                  FUNC_DRAW, FUNC_DRAW_CLIP: begin
                     state_in   = ST_READ;
                     clipped_in = (req_func == FUNC_DRAW_CLIP);
                     blank_in   = !code_ok;
                     code_in    = req_char_code[CODE_W-1:0];
                     row_in     = '0;
                     col_lo_in  = col_off;
                     col_hi_in  = {1'b0, col_off} + width_eff;
                     scale_in   = scale_eff;
                     ox_in      = req_origin_x;
                     py_in      = 18'(req_origin_y);
                     colour_in  = req_colour;
                     min_x_in   = req_clip_min_x;
                     min_y_in   = req_clip_min_y;
                     max_x_in   = req_clip_max_x;
                     max_y_in   = req_clip_max_y;
                     hold_v_in  = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            // row fetch; the vertical clamp is settled once per row here
            mem_rd_en = 1'b1;
            px_in     = 18'(ox_ff);
            col_in    = '0;
            state_in  = ST_SCAN;
            if (clipped_ff) begin
               y_in    = 17'(y_lo);
               h_in    = 7'(y_hi - y_lo);
               y_ok_in = y_hi > y_lo;
            end else begin
               y_in    = 17'(py_ff);
               h_in    = scale_ff;
               y_ok_in = 1'b1;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               if (emit) begin
                  hold_v_in = 1'b1;
                  hold_x_in = xspan.x;
                  hold_y_in = y_ff;
                  hold_w_in = xspan.w;
                  hold_h_in = h_ff;
                  if (hold_v_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_x_in      = hold_x_ff;
                     rsp_y_in      = hold_y_ff;
                     rsp_w_in      = hold_w_ff;
                     rsp_h_in      = hold_h_ff;
                     rsp_colour_in = colour_ff;
                     rsp_empty_in  = 1'b0;
                     rsp_last_in   = 1'b0;
                  end
               end
               col_in = col_ff + 1'b1;
               px_in  = px_ff + scale_s;
               if (col_ff == 3'd7) begin
                  row_in   = row_ff + 1'b1;
                  py_in    = py_end;
                  state_in = (row_ff == 3'd7) ? ST_DONE : ST_READ;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               hold_v_in    = 1'b0;
               state_in     = ST_IDLE;
               if (hold_v_ff) begin
                  rsp_x_in      = hold_x_ff;
                  rsp_y_in      = hold_y_ff;
                  rsp_w_in      = hold_w_ff;
                  rsp_h_in      = hold_h_ff;
                  rsp_colour_in = colour_ff;
                  rsp_empty_in  = 1'b0;
               end else begin
                  rsp_x_in      = '0;
                  rsp_y_in      = '0;
                  rsp_w_in      = '0;
                  rsp_h_in      = '0;
                  rsp_colour_in = '0;
                  rsp_empty_in  = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      clipped_ff    <= clipped_in;
      blank_ff      <= blank_in;
      code_ff       <= code_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      col_lo_ff     <= col_lo_in;
      col_hi_ff     <= col_hi_in;
      scale_ff      <= scale_in;
      ox_ff         <= ox_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      colour_ff     <= colour_in;
      min_x_ff      <= min_x_in;
      min_y_ff      <= min_y_in;
      max_x_ff      <= max_x_in;
      max_y_ff      <= max_y_in;
      y_ff          <= y_in;
      h_ff          <= h_in;
      y_ok_ff       <= y_ok_in;
      hold_x_ff     <= hold_x_in;
      hold_y_ff     <= hold_y_in;
      hold_w_ff     <= hold_w_in;
      hold_h_ff     <= hold_h_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_w_ff      <= rsp_w_in;
      rsp_h_ff      <= rsp_h_in;
      rsp_colour_ff <= rsp_colour_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rect_x      = rsp_x_ff;
   assign rsp_rect_y      = rsp_y_ff;
   assign rsp_rect_w      = rsp_w_ff;
   assign rsp_rect_h      = rsp_h_ff;
   assign rsp_rect_colour = rsp_colour_ff;
   assign rsp_empty_res   = rsp_empty_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

>>> rtl/bitmap_glyph_rasterizer_clipped_unit.sv
// Top level of the bitmap glyph rasterizer: config registers, glyph store, sequencer.
//
// Input channel (req_*): a load item writes one row byte of one glyph into the
// store; a draw item scans the eight rows of one glyph and returns one square
// (or clamped rectangle) per visible set dot on the rsp_* channel, rsp_last marking the
// final one. A draw with no visible dot returns one result with empty_res set.
// Loads and unused function codes return nothing and leave the sequencer idle.
// In a draw each row is one registered store read followed by eight column steps
// of the position accumulator, then a done state releases the final result.
// One item is in work at a time; the next item is taken once the last result
// has moved into the output register. Results leave through an output register
// backed by a one-entry hold stage, so a result reaches the output register only
// when the next visible dot is found or the draw ends. When the receiver stalls,
// the scan waits at the next visible dot until room frees up.
// After reset the glyph store is zeroed by a sweep over all GLYPH_COUNT*8 entries
// (2048 at the default) during which req_ready stays low; config writes
// (csr_we, csr_index, csr_wdata) are taken at any time, and are expected only
// while no draw is in work. glyph_width resets to 8, row_shift to 0.
module bitmap_glyph_rasterizer_clipped_unit import bgr_pkg::*; #(
   parameter int GLYPH_COUNT = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [7:0]         req_char_code,
   input  logic [2:0]         req_row_index,
   input  logic [7:0]         req_row_bits,
   input  logic signed [15:0] req_origin_x,
   input  logic signed [15:0] req_origin_y,
   input  logic [6:0]         req_scale,
   input  logic [31:0]        req_colour,
   input  logic signed [15:0] req_clip_min_x,
   input  logic signed [15:0] req_clip_min_y,
   input  logic signed [15:0] req_clip_max_x,
   input  logic signed [15:0] req_clip_max_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [16:0] rsp_rect_x,
   output logic signed [16:0] rsp_rect_y,
   output logic [6:0]         rsp_rect_w,
   output logic [6:0]         rsp_rect_h,
   output logic [31:0]        rsp_rect_colour,
   output logic               rsp_empty_res,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [3:0]         csr_wdata
);

   localparam int ADDR_W = $clog2(GLYPH_COUNT) + ROW_W;

   logic [3:0]        glyph_width_ff, glyph_width_in;
   logic [2:0]        row_shift_ff, row_shift_in;
   logic              mem_busy;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [7:0]        mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [7:0]        mem_rd_data;

   always_comb begin
      glyph_width_in = glyph_width_ff;
      row_shift_in   = row_shift_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GLYPH_WIDTH: glyph_width_in = csr_wdata;
            CSR_ROW_SHIFT:   row_shift_in   = csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_width_ff <= GLYPH_WIDTH_RESET;
         row_shift_ff   <= '0;
      end else begin
         glyph_width_ff <= glyph_width_in;
         row_shift_ff   <= row_shift_in;
      end
   end

   bgr_glyph_mem #(
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .busy    (mem_busy)
   );

   bgr_draw_seq #(
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_char_code   (req_char_code),
      .req_row_index   (req_row_index),
      .req_row_bits    (req_row_bits),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_scale       (req_scale),
      .req_colour      (req_colour),
      .req_clip_min_x  (req_clip_min_x),
      .req_clip_min_y  (req_clip_min_y),
      .req_clip_max_x  (req_clip_max_x),
      .req_clip_max_y  (req_clip_max_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rect_x      (rsp_rect_x),
      .rsp_rect_y      (rsp_rect_y),
      .rsp_rect_w      (rsp_rect_w),
      .rsp_rect_h      (rsp_rect_h),
      .rsp_rect_colour (rsp_rect_colour),
      .rsp_empty_res   (rsp_empty_res),
      .rsp_last        (rsp_last),
      .glyph_width     (glyph_width_ff),
      .row_shift       (row_shift_ff),
      .mem_busy        (mem_busy),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   // no item is taken while the store is still being zeroed
   assert property (@(posedge clock) disable iff (reset)
      mem_busy |-> !req_ready)
      else $error("item taken during store clear");

   // a draw occupies the sequencer for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready &&
       (req_func == FUNC_DRAW || req_func == FUNC_DRAW_CLIP)) |=> !req_ready)
      else $error("draw did not hold off the next item");

   // an empty draw result is the only one of its draw and carries no rectangle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |->
         (rsp_last && rsp_rect_w == 7'd0 && rsp_rect_h == 7'd0 &&
          rsp_rect_colour == 32'd0))
      else $error("malformed empty result");

   // every real rectangle has a nonzero size no larger than one dot
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_empty_res) |->
         (rsp_rect_w != 7'd0 && rsp_rect_h != 7'd0 &&
          rsp_rect_w <= 7'(SCALE_MAX) && rsp_rect_h <= 7'(SCALE_MAX)))
      else $error("rectangle size out of range");

endmodule

>>> tb/sv/testbench.sv
// Testbench for the glyph rasterizer: directed table, random phases, predictor and checker.
`timescale 1ns / 1ps

module testbench import bgr_pkg::*;;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 75;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 80;
   localparam int DRAIN_CYCLES  = 100;
   localparam int STALL_LIMIT   = 20000;
   localparam int REPORT_MAX    = 10;

   typedef struct packed {
      logic [1:0]         func;
      logic [7:0]         code;
      logic [2:0]         ridx;
      logic [7:0]         rbits;
      logic signed [15:0] ox;
      logic signed [15:0] oy;
      logic [6:0]         scale;
      logic [31:0]        colour;
      logic signed [15:0] cminx;
      logic signed [15:0] cminy;
      logic signed [15:0] cmaxx;
      logic signed [15:0] cmaxy;
   } glyph_req_t;

   typedef struct packed {
      logic signed [16:0] x;
      logic signed [16:0] y;
      logic [6:0]         w;
      logic [6:0]         h;
      logic [31:0]        colour;
      logic               empty;
      logic               last;
   } rect_t;

   typedef struct packed {
      glyph_req_t req;
      logic       typed;
      rect_t      want;
   } directed_row_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_func = FUNC_LOAD;
   logic [7:0]         req_char_code = '0;
   logic [2:0]         req_row_index = '0;
   logic [7:0]         req_row_bits = '0;
   logic signed [15:0] req_origin_x = '0;
   logic signed [15:0] req_origin_y = '0;
   logic [6:0]         req_scale = '0;
   logic [31:0]        req_colour = '0;
   logic signed [15:0] req_clip_min_x = '0;
   logic signed [15:0] req_clip_min_y = '0;
   logic signed [15:0] req_clip_max_x = '0;
   logic signed [15:0] req_clip_max_y = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [16:0] rsp_rect_x;
   logic signed [16:0] rsp_rect_y;
   logic [6:0]         rsp_rect_w;
   logic [6:0]         rsp_rect_h;
   logic [31:0]        rsp_rect_colour;
   logic               rsp_empty_res;
   logic               rsp_last;
   logic               csr_we = 1'b0;
   logic               csr_index = CSR_GLYPH_WIDTH;
   logic [3:0]         csr_wdata = '0;

   // predictor state
   logic [7:0] font_rows [256][8];
   logic [3:0] cfg_width;
   logic [2:0] cfg_shift;
   rect_t      pending_rects [$];
   logic [7:0] hot_codes [16];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int stall_cycles = 0;
   int mismatches = 0;
   int n_loads = 0, n_draws = 0, n_clipped = 0, n_ignored = 0;
   int n_results = 0, n_empty = 0;
   rect_t got_rect, want_rect;

   bitmap_glyph_rasterizer_clipped_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic rect_t mk_rect(input int x, input int y, input int w, input int h,
                                     input logic [31:0] col, input logic e, input logic l);
      rect_t r;
      r.x = x[16:0];
      r.y = y[16:0];
      r.w = w[6:0];
      r.h = h[6:0];
      r.colour = col;
      r.empty = e;
      r.last = l;
      return r;
   endfunction

   function automatic glyph_req_t mk_req(input logic [1:0] f, input int code, input int row,
                                         input int bits, input int ox, input int oy,
                                         input int sc, input logic [31:0] col,
                                         input int x0, input int y0, input int x1, input int y1);
      glyph_req_t r;
      r.func = f;
      r.code = code[7:0];
      r.ridx = row[2:0];
      r.rbits = bits[7:0];
      r.ox = ox[15:0];
      r.oy = oy[15:0];
      r.scale = sc[6:0];
      r.colour = col;
      r.cminx = x0[15:0];
      r.cminy = y0[15:0];
      r.cmaxx = x1[15:0];
      r.cmaxy = y1[15:0];
      return r;
   endfunction

   // Updates the glyph store for loads; queues the squares a draw should produce.
   function automatic void rasterize_item(input glyph_req_t it);
      rect_t      found [64];
      rect_t      r;
      logic [7:0] data;
      logic       clip;
      int n, s, w, off, cc, ox, oy, px, py, cminx, cminy, cmaxx, cmaxy, x1, y1, x2, y2;
      if (it.func == FUNC_LOAD) begin
         font_rows[it.code][it.ridx] = it.rbits;
         return;
      end
      if (it.func != FUNC_DRAW && it.func != FUNC_DRAW_CLIP)
         return;
      clip = (it.func == FUNC_DRAW_CLIP);
      s = it.scale;
      if (s < 1) s = 1;
      if (s > SCALE_MAX) s = SCALE_MAX;
      w = (cfg_width >= 1 && cfg_width <= CELL_COLS) ? cfg_width : CELL_COLS;
      off = (CELL_COLS - w) / 2;
      ox = $signed(it.ox);
      oy = $signed(it.oy);
      cminx = $signed(it.cminx);
      cminy = $signed(it.cminy);
      cmaxx = $signed(it.cmaxx);
      cmaxy = $signed(it.cmaxy);
      n = 0;
      for (int row = 0; row < 8; row++) begin
         py = oy + row * s;
         data = font_rows[it.code][row] << cfg_shift;
         for (int col = 0; col < w; col++) begin
            cc = off + col;
            if (!data[7 - cc])
               continue;
            px = ox + cc * s;
            if (!clip) begin
               found[n] = mk_rect(px, py, s, s, it.colour, 1'b0, 1'b0);
               n++;
               continue;
            end
            // clamping covers both the whole-square and the straddling case
            x1 = (px > cminx) ? px : cminx;
            y1 = (py > cminy) ? py : cminy;
            x2 = (px + s < cmaxx) ? px + s : cmaxx;
            y2 = (py + s < cmaxy) ? py + s : cmaxy;
            if (x2 > x1 && y2 > y1) begin
               found[n] = mk_rect(x1, y1, x2 - x1, y2 - y1, it.colour, 1'b0, 1'b0);
               n++;
            end
         end
      end
      if (n == 0)
         pending_rects.push_back(mk_rect(0, 0, 0, 0, '0, 1'b1, 1'b1));
      for (int k = 0; k < n; k++) begin
         r = found[k];
         r.last = (k == n - 1);
         pending_rects.push_back(r);
      end
   endfunction

   function automatic logic [7:0] pick_code(input int hot_pct);
      if ($urandom_range(0, 99) < hot_pct)
         return hot_codes[$urandom_range(0, 15)];
      return $urandom_range(0, 255);
   endfunction

   function automatic glyph_req_t load_item(input logic [7:0] code, input logic [2:0] row);
      glyph_req_t r;
      int sel;
      r = {$urandom, $urandom, $urandom, $urandom, $urandom};
      r.func = FUNC_LOAD;
      r.code = code;
      r.ridx = row;
      sel = $urandom_range(0, 99);
      if (sel < 20)
         r.rbits = 8'hFF;
      else if (sel < 30)
         r.rbits = 8'h00;
      return r;
   endfunction

   function automatic glyph_req_t draw_item(input logic [7:0] code);
      glyph_req_t r;
      int sel, s, sc, ox, oy, x0, y0, x1, y1;
      r = {$urandom, $urandom, $urandom, $urandom, $urandom};
      r.func = $urandom_range(0, 1) ? FUNC_DRAW_CLIP : FUNC_DRAW;
      r.code = code;
      sel = $urandom_range(0, 99);
      if (sel < 70)
         s = $urandom_range(1, 8);
      else if (sel < 90)
         s = $urandom_range(9, 64);
      else
         s = $urandom_range(0, 127);
      r.scale = s[6:0];
      sc = (s < 1) ? 1 : (s > SCALE_MAX) ? SCALE_MAX : s;
      if ($urandom_range(0, 3) != 0) begin
         ox = $urandom_range(0, 800) - 400;
         oy = $urandom_range(0, 800) - 400;
         r.ox = ox[15:0];
         r.oy = oy[15:0];
      end else begin
         ox = $signed(r.ox);
         oy = $signed(r.oy);
      end
      // mostly a window around the cell so clamping gets exercised
      if ($urandom_range(0, 3) != 0) begin
         x0 = ox - sc + $urandom_range(0, 6 * sc);
         y0 = oy - sc + $urandom_range(0, 6 * sc);
         x1 = x0 - sc + $urandom_range(0, 8 * sc);
         y1 = y0 - sc + $urandom_range(0, 8 * sc);
         r.cminx = x0[15:0];
         r.cminy = y0[15:0];
         r.cmaxx = x1[15:0];
         r.cmaxy = y1[15:0];
      end
      return r;
   endfunction

   task automatic offer_item(input glyph_req_t it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= it.func;
      req_char_code <= it.code;
      req_row_index <= it.ridx;
      req_row_bits <= it.rbits;
      req_origin_x <= it.ox;
      req_origin_y <= it.oy;
      req_scale <= it.scale;
      req_colour <= it.colour;
      req_clip_min_x <= it.cminx;
      req_clip_min_y <= it.cminy;
      req_clip_max_x <= it.cmaxx;
      req_clip_max_y <= it.cmaxy;
      do @(posedge clock); while (!req_ready);
      case (it.func)
         FUNC_LOAD:      n_loads++;
         FUNC_DRAW:      n_draws++;
         FUNC_DRAW_CLIP: begin
            n_draws++;
            n_clipped++;
         end
         default:        n_ignored++;
      endcase
   endtask

   task automatic send_and_predict(input glyph_req_t it);
      offer_item(it);
      rasterize_item(it);
   endtask

   // block must be idle: all results back, then let any load finish
   task automatic set_config(input int width, input int shift);
      req_valid <= 1'b0;
      while (pending_rects.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_GLYPH_WIDTH;
      csr_wdata <= width[3:0];
      @(posedge clock);
      cfg_width = width[3:0];
      csr_index <= CSR_ROW_SHIFT;
      csr_wdata <= {1'($urandom_range(0, 1)), shift[2:0]};
      @(posedge clock);
      cfg_shift = shift[2:0];
      csr_we <= 1'b0;
   endtask

   task automatic set_idle(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 9;
            recv_idle_pct = 54;
         end
         1: begin
            send_idle_pct = 54;
            recv_idle_pct = 9;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   // receiver: random back-pressure plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_taken != hold_requests) begin
         hold_taken <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_rect = {rsp_rect_x, rsp_rect_y, rsp_rect_w, rsp_rect_h, rsp_rect_colour,
                     rsp_empty_res, rsp_last};
         n_results++;
         if (rsp_empty_res)
            n_empty++;
         if (pending_rects.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: rectangle with nothing outstanding: x=%0d y=%0d w=%0d h=%0d",
                        $realtime, got_rect.x, got_rect.y, got_rect.w, got_rect.h);
         end else begin
            want_rect = pending_rects.pop_front();
            if (got_rect !== want_rect) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("%0t: got  x=%0d y=%0d w=%0d h=%0d colour=%h empty=%b last=%b",
                           $realtime, got_rect.x, got_rect.y, got_rect.w, got_rect.h,
                           got_rect.colour, got_rect.empty, got_rect.last);
                  $display("%0t: want x=%0d y=%0d w=%0d h=%0d colour=%h empty=%b last=%b",
                           $realtime, want_rect.x, want_rect.y, want_rect.w, want_rect.h,
                           want_rect.colour, want_rect.empty, want_rect.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d rectangles outstanding",
                  $realtime, stall_cycles, pending_rects.size());
         $display("** bitmap_glyph_rasterizer_clipped_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      directed_row_t dir_rows [$];
      glyph_req_t    it;
      logic [7:0]    code;
      int            budget, pick;
      int            phase_width [PHASES] = '{8, 0, 15, 1, 6, 0};
      int            phase_shift [PHASES] = '{0, 7, 1, 3, 5, 0};
      int            phase_mode  [PHASES] = '{0, 0, 1, 1, 2, 2};

      foreach (font_rows[c, r])
         font_rows[c][r] = '0;
      cfg_width = GLYPH_WIDTH_RESET;
      cfg_shift = '0;
      foreach (hot_codes[i])
         hot_codes[i] = $urandom_range(0, 255);
      phase_width[5] = $urandom_range(0, 15);
      phase_shift[5] = $urandom_range(0, 7);

      // reset config: width 8, no shift, blank store
      dir_rows.push_back('{mk_req(FUNC_DRAW, 0, 0, 0, 10, 20, 3, 32'hCAFE0001, 0, 0, 0, 0),
                           1'b1, mk_rect(0, 0, 0, 0, '0, 1'b1, 1'b1)});
      dir_rows.push_back('{mk_req(FUNC_DRAW_CLIP, 255, 0, 0, 0, 0, 2, 32'h1,
                                  -32768, -32768, 32767, 32767),
                           1'b1, mk_rect(0, 0, 0, 0, '0, 1'b1, 1'b1)});
      dir_rows.push_back('{mk_req(FUNC_LOAD, 255, 0, 8'h80, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
      dir_rows.push_back('{mk_req(FUNC_DRAW, 255, 0, 0, 100, 200, 1, 32'h12345678, 0, 0, 0, 0),
                           1'b1, mk_rect(100, 200, 1, 1, 32'h12345678, 1'b0, 1'b1)});
      dir_rows.push_back('{mk_req(FUNC_LOAD, 255, 7, 8'h01, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
      // scale 0 acts as 1, scale above 64 acts as 64
      dir_rows.push_back('{mk_req(FUNC_DRAW, 255, 0, 0, -5, -7, 0, 32'hA5A5A5A5, 0, 0, 0, 0),
                           1'b0, '0});
      dir_rows.push_back('{mk_req(FUNC_DRAW, 255, 0, 0, 32767, 32767, 127, 32'hFFFFFFFF,
                                  0, 0, 0, 0), 1'b0, '0});
      dir_rows.push_back('{mk_req(FUNC_DRAW, 255, 0, 0, -32768, -32768, 64, 32'h0,
                                  0, 0, 0, 0), 1'b0, '0});
      // unused function code must leave the store alone
      dir_rows.push_back('{mk_req(FUNC_UNUSED, 255, 0, 8'hFF, 0, 0, 1, 32'h5, 0, 0, 9, 9),
                           1'b0, '0});
      dir_rows.push_back('{mk_req(FUNC_DRAW, 255, 0, 0, 0, 0, 2, 32'h77, 0, 0, 0, 0), 1'b0, '0});
      // inverted window, then window that misses every dot
      dir_rows.push_back('{mk_req(FUNC_DRAW_CLIP, 255, 0, 0, 0, 0, 4, 32'h9, 50, 50, 10, 10),
                           1'b1, mk_rect(0, 0, 0, 0, '0, 1'b1, 1'b1)});
      dir_rows.push_back('{mk_req(FUNC_DRAW_CLIP, 255, 0, 0, 0, 0, 4, 32'h9, 100, 100, 200, 200),
                           1'b1, mk_rect(0, 0, 0, 0, '0, 1'b1, 1'b1)});
      dir_rows.push_back('{mk_req(FUNC_LOAD, 0, 3, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
      dir_rows.push_back('{mk_req(FUNC_LOAD, 0, 4, 8'hAA, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
      // straddling window clamps edge squares
      dir_rows.push_back('{mk_req(FUNC_DRAW_CLIP, 0, 0, 0, 0, 0, 8, 32'hBEEF, 4, 26, 60, 36),
                           1'b0, '0});
      dir_rows.push_back('{mk_req(FUNC_DRAW_CLIP, 0, 0, 0, 0, 0, 8, 32'hBEEF,
                                  -32768, -32768, 32767, 32767), 1'b0, '0});
      dir_rows.push_back('{mk_req(FUNC_DRAW, 0, 0, 0, -20, 30, 5, 32'h00FF00FF, 0, 0, 0, 0),
                           1'b0, '0});
      dir_rows.push_back('{mk_req(FUNC_LOAD, 255, 0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
      dir_rows.push_back('{mk_req(FUNC_DRAW_CLIP, 255, 0, 0, 0, 0, 1, 32'h3C3C3C3C, 0, 0, 8, 8),
                           1'b1, mk_rect(7, 7, 1, 1, 32'h3C3C3C3C, 1'b0, 1'b1)});
      dir_rows.push_back('{mk_req(FUNC_UNUSED, 0, 3, 8'h00, 0, 0, 1, 32'h5, 0, 0, 9, 9),
                           1'b0, '0});
      dir_rows.push_back('{mk_req(FUNC_LOAD, 128, 5, 8'h7E, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
      dir_rows.push_back('{mk_req(FUNC_DRAW, 128, 0, 0, 1000, -1000, 64, 32'h80000000,
                                  0, 0, 0, 0), 1'b0, '0});

      while (reset) @(posedge clock);
      set_idle(0);
      foreach (dir_rows[i]) begin
         offer_item(dir_rows[i].req);
         if (dir_rows[i].typed)
            pending_rects.push_back(dir_rows[i].want);
         else
            rasterize_item(dir_rows[i].req);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         set_idle(phase_mode[ph]);
         set_config(phase_width[ph], phase_shift[ph]);
         if (ph == 1)
            hold_requests <= hold_requests + 1;
         budget = 0;
         while (budget < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
               it = {$urandom, $urandom, $urandom, $urandom, $urandom};
               it.func = FUNC_UNUSED;
               send_and_predict(it);
            end else if (pick < 20) begin
               // whole glyph loaded, then drawn
               code = pick_code(90);
               for (int r = 0; r < 8; r++)
                  send_and_predict(load_item(code, r[2:0]));
               send_and_predict(draw_item(code));
               budget += 9;
            end else if (pick < 55) begin
               send_and_predict(load_item(pick_code(85), 3'($urandom_range(0, 7))));
               budget++;
            end else begin
               send_and_predict(draw_item(pick_code(80)));
               budget++;
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_rects.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d loads, %0d draws (%0d clipped), %0d ignored items",
               n_loads, n_draws, n_clipped, n_ignored);
      $display("%0d rectangles returned, %0d empty draws, 7 width/shift settings, %0d errors",
               n_results, n_empty, mismatches);
      if (mismatches == 0)
         $display("** bitmap_glyph_rasterizer_clipped_unit: PASSED **");
      else
         $display("** bitmap_glyph_rasterizer_clipped_unit: FAILED **");
      $finish;
   end

endmodule
